// File: rtl/assert_macros.svh
// Assertion macros for the RTL of the I2C master read engine.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted (active low).
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/i2cmr_pkg.sv
// Types and constants of the I2C master read engine.
// No dependencies; imported by i2cmr_engine and i2c_master_read_transaction.
`default_nettype none

package i2cmr_pkg;

    localparam logic [4:0]  MAX_BYTES         = 5'd16;
    localparam logic [7:0]  ADDR_BYTE_RST     = 8'hB5;
    localparam logic [15:0] HALF_PERIOD_RST   = 16'd10;
    localparam logic [7:0]  ACK_TIMEOUT_RST   = 8'd250;

    // Configuration register indexes.
    localparam logic [1:0]  CFG_ADDRESS_BYTE  = 2'd0;
    localparam logic [1:0]  CFG_HALF_PERIOD   = 2'd1;
    localparam logic [1:0]  CFG_ACK_TIMEOUT   = 2'd2;

    // Status codes.
    localparam logic [2:0]  ST_RUN            = 3'd0;
    localparam logic [2:0]  ST_DONE           = 3'd1;
    localparam logic [2:0]  ST_BUSY           = 3'd2;
    localparam logic [2:0]  ST_START_ERR      = 3'd3;
    localparam logic [2:0]  ST_NACK           = 3'd4;

    typedef enum logic [14:0] {
        PH_IDLE     = 15'b000000000000001,
        PH_CHECK    = 15'b000000000000010,
        PH_SDA_LOW  = 15'b000000000000100,
        PH_SCL_LOW  = 15'b000000000001000,
        PH_ADDR_LO  = 15'b000000000010000,
        PH_ADDR_HI  = 15'b000000000100000,
        PH_ACK_LO   = 15'b000000001000000,
        PH_ACK_HI   = 15'b000000010000000,
        PH_RD_LO    = 15'b000000100000000,
        PH_RD_HI    = 15'b000001000000000,
        PH_MACK_LO  = 15'b000010000000000,
        PH_MACK_HI  = 15'b000100000000000,
        PH_STOP_LO  = 15'b001000000000000,
        PH_STOP_HI  = 15'b010000000000000,
        PH_STOP_REL = 15'b100000000000000
    } t_phase;

    typedef struct packed {
        logic [7:0]  address_byte;
        logic [15:0] half_period_ticks;
        logic [7:0]  ack_timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic       sda_sample;
        logic [4:0] byte_count;
        logic       start_request;
    } t_item;

    typedef struct packed {
        logic [2:0] status;
        logic       last_byte;
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       sda_level;
        logic       scl_level;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/i2cmr_engine.sv
// Bus timing engine: phase register, counters and the per-tick step logic.
// Depends on i2cmr_pkg.
`default_nettype none

module i2cmr_engine
    import i2cmr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_fire,
    input  wire t_item   i_item,
    input  wire t_cfg    i_cfg,
    output t_result      o_result
);

    t_phase      r_phase,   n_phase;
    logic [15:0] r_tick,    n_tick;
    logic [3:0]  r_bit,     n_bit;
    logic [7:0]  r_shift,   n_shift;
    logic [4:0]  r_bytes,   n_bytes;
    logic [7:0]  r_ackw,    n_ackw;

    logic [15:0] w_h;
    logic        w_tick_last;
    logic [15:0] w_tick_adv;
    logic [3:0]  w_bit_inc;
    logic [7:0]  w_rd_shift;
    logic [4:0]  w_bytes_dec;
    logic [4:0]  w_count;
    logic        w_final;

    always_comb begin
        w_h         = (i_cfg.half_period_ticks == 16'd0) ? 16'd1 : i_cfg.half_period_ticks;
        w_tick_last = ({1'b0, r_tick} + 17'd1) >= {1'b0, w_h};
        w_tick_adv  = w_tick_last ? 16'd0 : r_tick + 16'd1;
        w_bit_inc   = r_bit + 4'd1;
        w_rd_shift  = {r_shift[6:0], i_item.sda_sample};
        w_bytes_dec = (r_bytes == 5'd0) ? 5'd0 : r_bytes - 5'd1;
        w_final     = (r_bytes <= 5'd1);
        if (i_item.byte_count == 5'd0) begin
            w_count = 5'd1;
        end else if (i_item.byte_count > MAX_BYTES) begin
            w_count = MAX_BYTES;
        end else begin
            w_count = i_item.byte_count;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_bytes = r_bytes;
        n_ackw  = r_ackw;
        o_result = '{status: ST_RUN, last_byte: 1'b0, byte_valid: 1'b0,
                     data_byte: 8'd0, sda_level: 1'b1, scl_level: 1'b1};

        unique case (r_phase)
            PH_IDLE: begin
                if (i_item.start_request) begin
                    n_bytes = w_count;
                    n_tick  = 16'd0;
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_tick = w_tick_adv;
                if (w_tick_last) begin
                    if (!i_item.sda_sample) begin
                        o_result.status = ST_BUSY;
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_SDA_LOW;
                    end
                end
            end
            PH_SDA_LOW: begin
                o_result.sda_level = 1'b0;
                n_tick = w_tick_adv;
                if (w_tick_last) n_phase = PH_SCL_LOW;
            end
            PH_SCL_LOW: begin
                o_result.scl_level = 1'b0;
                o_result.sda_level = 1'b0;
                n_tick = w_tick_adv;
                if (w_tick_last) begin
                    if (i_item.sda_sample) begin
                        o_result.status = ST_START_ERR;
                        n_phase = PH_IDLE;
                    end else begin
                        n_shift = i_cfg.address_byte;
                        n_bit   = 4'd0;
                        n_phase = PH_ADDR_LO;
                    end
                end
            end
            PH_ADDR_LO: begin
                o_result.scl_level = 1'b0;
                o_result.sda_level = r_shift[7];
                n_tick = w_tick_adv;
                if (w_tick_last) n_phase = PH_ADDR_HI;
            end
            PH_ADDR_HI: begin
                o_result.sda_level = r_shift[7];
                n_tick = w_tick_adv;
                if (w_tick_last) begin
                    n_shift = {r_shift[6:0], 1'b0};
                    n_bit   = w_bit_inc;
                    if (w_bit_inc >= 4'd8) begin
                        n_ackw  = 8'd0;
                        n_phase = PH_ACK_LO;
                    end else begin
                        n_phase = PH_ADDR_LO;
                    end
                end
            end
            PH_ACK_LO: begin
                o_result.scl_level = 1'b0;
                n_tick = w_tick_adv;
                if (w_tick_last) n_phase = PH_ACK_HI;
            end
            PH_ACK_HI: begin
                // Settle for one half period, then poll SDA once per tick.
                if (!w_tick_last) begin
                    n_tick = r_tick + 16'd1;
                end else if (!i_item.sda_sample) begin
                    n_tick  = 16'd0;
                    n_bit   = 4'd0;
                    n_shift = 8'd0;
                    n_phase = PH_RD_LO;
                end else if (r_ackw >= i_cfg.ack_timeout_ticks) begin
                    // The stop steps carry the final status in the bit counter.
                    n_tick  = 16'd0;
                    n_bit   = {1'b0, ST_NACK};
                    n_phase = PH_STOP_LO;
                end else begin
                    n_ackw = r_ackw + 8'd1;
                end
            end
            PH_RD_LO: begin
                o_result.scl_level = 1'b0;
                n_tick = w_tick_adv;
                if (w_tick_last) n_phase = PH_RD_HI;
            end
            PH_RD_HI: begin
                n_tick = w_tick_adv;
                if (w_tick_last) begin
                    n_shift = w_rd_shift;
                    n_bit   = w_bit_inc;
                    if (w_bit_inc >= 4'd8) begin
                        o_result.byte_valid = 1'b1;
                        o_result.data_byte  = w_rd_shift;
                        o_result.last_byte  = w_final;
                        n_phase = PH_MACK_LO;
                    end else begin
                        n_phase = PH_RD_LO;
                    end
                end
            end
            PH_MACK_LO: begin
                o_result.scl_level = 1'b0;
                o_result.sda_level = w_final;
                n_tick = w_tick_adv;
                if (w_tick_last) n_phase = PH_MACK_HI;
            end
            PH_MACK_HI: begin
                o_result.sda_level = w_final;
                n_tick = w_tick_adv;
                if (w_tick_last) begin
                    n_bytes = w_bytes_dec;
                    if (w_bytes_dec == 5'd0) begin
                        n_bit   = {1'b0, ST_DONE};
                        n_phase = PH_STOP_LO;
                    end else begin
                        n_bit   = 4'd0;
                        n_shift = 8'd0;
                        n_phase = PH_RD_LO;
                    end
                end
            end
            PH_STOP_LO: begin
                o_result.scl_level = 1'b0;
                o_result.sda_level = 1'b0;
                n_tick = w_tick_adv;
                if (w_tick_last) n_phase = PH_STOP_HI;
            end
            PH_STOP_HI: begin
                o_result.sda_level = 1'b0;
                n_tick = w_tick_adv;
                if (w_tick_last) n_phase = PH_STOP_REL;
            end
            PH_STOP_REL: begin
                n_tick = w_tick_adv;
                if (w_tick_last) begin
                    o_result.status = r_bit[2:0];
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_tick  = 16'd0;
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= 16'd0;
            r_bit   <= 4'd0;
            r_shift <= 8'd0;
            r_bytes <= 5'd0;
            r_ackw  <= 8'd0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_bytes <= n_bytes;
            r_ackw  <= n_ackw;
        end
    end

endmodule

`default_nettype wire

// File: rtl/i2c_master_read_transaction.sv
// I2C master read engine, one bus timing tick per request on the input stream.
// Channels: s_axis carries one tick (start flag, byte count, sampled SDA);
// m_axis returns one result per tick (SCL/SDA drive, received byte, status),
// with tlast marking the final received byte of a transaction. The cfg port
// writes address_byte (index 0), half_period_ticks (1) and ack_timeout_ticks
// (2); writes to other indexes are dropped. Write it only while idle.
// Throughput: one request per clock cycle while the receiver takes results; the
// step logic in i2cmr_engine is combinational between the input register and the result register.
// Each request is held in the input register; its result is presented from the result register.
// A stalled receiver holds the result register; the input register keeps one
// further request and then tready drops until the result is taken.
// Reset (synchronous, active low) empties both registers, returns the engine
// to idle and loads the configuration defaults (0xB5, 10, 250).
`default_nettype none
`include "assert_macros.svh"

module i2c_master_read_transaction
    import i2cmr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input ticks. tdata: [0] start_request, [5:1] byte_count, [6] sda_sample, [7] ignored.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,
    // Results. tdata: [0] scl_level, [1] sda_level, [9:2] data_byte,
    // [10] byte_valid, [13:11] status, [15:14] zero.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast,
    // Configuration writes.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;
    t_result w_result;
    logic    w_advance;
    logic    w_fire;
    logic    w_out_byte;

    assign w_advance       = !r_out_valid || i_m_axis_tready;
    assign w_fire          = r_in_valid && w_advance;
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.address_byte      <= ADDR_BYTE_RST;
            r_cfg.half_period_ticks <= HALF_PERIOD_RST;
            r_cfg.ack_timeout_ticks <= ACK_TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ADDRESS_BYTE: r_cfg.address_byte      <= i_cfg_data[7:0];
                CFG_HALF_PERIOD:  r_cfg.half_period_ticks <= i_cfg_data;
                CFG_ACK_TIMEOUT:  r_cfg.ack_timeout_ticks <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_item <= t_item'(i_s_axis_tdata[6:0]);
        end
    end

    i2cmr_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out.status, r_out.byte_valid, r_out.data_byte,
                              r_out.sda_level, r_out.scl_level};
    assign o_m_axis_tlast  = r_out.last_byte;

    assign w_out_byte = r_out_valid && r_out.byte_valid;

    `ASSERT_CLK(a_fire_loads_out, i_clk, i_rst_n, w_fire |=> r_out_valid, "result not loaded")
    `ASSERT_CLK(a_in_holds, i_clk, i_rst_n, r_in_valid && !w_advance |=> r_in_valid, "request lost")
    `ASSERT_CLK(a_byte_status, i_clk, i_rst_n, w_out_byte |-> r_out.status == ST_RUN, "byte status")
    `ASSERT_CLK(a_byte_scl_high, i_clk, i_rst_n, w_out_byte |-> r_out.scl_level, "byte with SCL low")

endmodule

`default_nettype wire
